// ===== design/shr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shr_pkg
// shared types and constants of the snapshot history ring
// ----------------------------------------------------------------------------
package shr_pkg;

    localparam int RING_SLOTS_DEF  = 8;
    localparam int MAX_ENTRIES_DEF = 8;
    localparam int RESULT_CAP      = 64;

    localparam int CMD_W   = 2;
    localparam int PID_W   = 31;
    localparam int LOAD_W  = 16;
    localparam int STAMP_W = 64;
    localparam int WANT_W  = 4;
    localparam int AGE_W   = 3;
    localparam int OAGE_W  = 4;
    localparam int CNT_W   = 4;
    localparam int RCNT_W  = $clog2(RESULT_CAP + 1);
    localparam int AGE_MAX = 7;

    localparam logic signed [OAGE_W-1:0] NO_ORIGIN = -4'sd1;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH = 2'd0,
        CMD_READ = 2'd1,
        CMD_FIND = 2'd2,
        CMD_NONE = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        KIND_ACK    = 2'd0,
        KIND_RECORD = 2'd1,
        KIND_SEARCH = 2'd2,
        KIND_NONE   = 2'd3
    } kind_t;

    typedef struct packed {
        cmd_t                 cmd;
        logic [PID_W-1:0]     entry_pid;
        logic [LOAD_W-1:0]    entry_load;
        logic                 entry_present;
        logic                 entry_last;
        logic [STAMP_W-1:0]   stamp_in;
        logic [STAMP_W-1:0]   now_time;
        logic [WANT_W-1:0]    want_count;
        logic [PID_W-1:0]     query_pid;
    } req_item_t;

    typedef struct packed {
        kind_t                     kind;
        logic [AGE_W-1:0]          age;
        logic [STAMP_W-1:0]        stamp_out;
        logic [PID_W-1:0]          pid_out;
        logic [LOAD_W-1:0]         load_out;
        logic                      present_out;
        logic                      snapshot_end;
        logic                      run_end;
        logic signed [OAGE_W-1:0]  origin_age;
        logic [CNT_W-1:0]          count_out;
        logic                      truncated;
    } rsp_item_t;

    // start of a ring walk, from the top level to the walker
    typedef struct packed {
        logic             start;
        logic             find;
        logic [PID_W-1:0] query_pid;
    } walk_req_t;

    // walker status back to the top level
    typedef struct packed {
        logic idle;
        logic rec_valid;
    } walk_stat_t;

endpackage

// ===== design/shr_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shr_ram
// simple dual port synchronous ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module shr_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 2
) (
    input  logic                      clk,
    input  logic                      wr_en,
    input  logic [$clog2(DEPTH)-1:0]  wr_addr,
    input  logic [DATA_W-1:0]         wr_data,
    input  logic                      rd_en,
    input  logic [$clog2(DEPTH)-1:0]  rd_addr,
    output logic [DATA_W-1:0]         rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read data holds while rd_en is low
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== design/shr_walk.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shr_walk
// ring walker for read and spike search, newest snapshot first
// ----------------------------------------------------------------------------
module shr_walk
    import shr_pkg::*;
#(
    parameter int RING_SLOTS  = RING_SLOTS_DEF,
    parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
    input  logic                                          clk,
    input  logic                                          rst_n,
    input  walk_req_t                                     walk_req,
    input  logic [$clog2(RING_SLOTS)-1:0]                 newest_slot,
    input  logic [$clog2(RING_SLOTS+1)-1:0]               filled,
    input  logic [$clog2(RING_SLOTS+1)-1:0]               copy,
    input  logic [LOAD_W-1:0]                             threshold,
    output logic                                          slot_rd_en,
    output logic [$clog2(RING_SLOTS)-1:0]                 slot_rd_addr,
    input  logic [STAMP_W+$clog2(MAX_ENTRIES+1)-1:0]      slot_rd_data,
    output logic                                          ent_rd_en,
    output logic [$clog2(RING_SLOTS*MAX_ENTRIES)-1:0]     ent_rd_addr,
    input  logic [PID_W+LOAD_W-1:0]                       ent_rd_data,
    output walk_stat_t                                    stat,
    output rsp_item_t                                     rec,
    input  logic                                          rec_take
);

    localparam int SW = $clog2(RING_SLOTS);
    localparam int FW = $clog2(RING_SLOTS + 1);
    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam int AW = $clog2(RING_SLOTS * MAX_ENTRIES);

    typedef enum logic [6:0] {
        W_IDLE     = 7'b0000001,
        W_SLOT_RD  = 7'b0000010,
        W_SLOT_DAT = 7'b0000100,
        W_ENT_RD   = 7'b0001000,
        W_CHECK    = 7'b0010000,
        W_EMIT     = 7'b0100000,
        W_FINISH   = 7'b1000000
    } walk_state_t;

    walk_state_t          state_reg, state_next;
    logic                 find_reg, find_next;
    logic [PID_W-1:0]     qpid_reg, qpid_next;
    logic [SW-1:0]        slot_ptr_reg, slot_ptr_next;
    logic [FW-1:0]        snap_reg, snap_next;
    logic [FW-1:0]        limit_reg, limit_next;
    logic [CW-1:0]        ent_reg, ent_next;
    logic [CW-1:0]        nent_reg, nent_next;
    logic [STAMP_W-1:0]   stamp_reg, stamp_next;
    logic [AW-1:0]        base_reg, base_next;
    logic [RCNT_W-1:0]    rcnt_reg, rcnt_next;
    logic                 found_reg, found_next;
    logic [AGE_W-1:0]     fage_reg, fage_next;

    logic [FW-1:0]        snap_inc;
    logic [CW-1:0]        ent_inc;
    logic [SW-1:0]        slot_prev;
    logic                 snap_last;
    logic                 run_last;
    logic [PID_W-1:0]     ent_pid;
    logic [LOAD_W-1:0]    ent_load;
    logic                 hit;

    assign snap_inc  = snap_reg + FW'(1);
    assign ent_inc   = ent_reg + CW'(1);
    assign slot_prev = (slot_ptr_reg == '0) ? SW'(RING_SLOTS - 1) : slot_ptr_reg - SW'(1);
    assign ent_pid   = ent_rd_data[LOAD_W +: PID_W];
    assign ent_load  = ent_rd_data[LOAD_W-1:0];
    assign hit       = (ent_pid == qpid_reg) && (ent_load >= threshold);
    assign snap_last = (nent_reg == '0) || (ent_inc == nent_reg);
    assign run_last  = (rcnt_reg == RCNT_W'(RESULT_CAP - 1))
                     || (snap_last && (snap_inc == limit_reg));

    assign slot_rd_en   = (state_reg == W_SLOT_RD);
    assign slot_rd_addr = slot_ptr_reg;
    assign ent_rd_en    = (state_reg == W_ENT_RD);
    assign ent_rd_addr  = base_reg + AW'(ent_reg);

    assign stat.idle      = (state_reg == W_IDLE);
    assign stat.rec_valid = (state_reg == W_EMIT) || (state_reg == W_FINISH);

    always_comb
    begin
        state_next    = state_reg;
        find_next     = find_reg;
        qpid_next     = qpid_reg;
        slot_ptr_next = slot_ptr_reg;
        snap_next     = snap_reg;
        limit_next    = limit_reg;
        ent_next      = ent_reg;
        nent_next     = nent_reg;
        stamp_next    = stamp_reg;
        base_next     = base_reg;
        rcnt_next     = rcnt_reg;
        found_next    = found_reg;
        fage_next     = fage_reg;

        unique case (state_reg)
            W_IDLE:
            begin
                if (walk_req.start)
                begin
                    find_next     = walk_req.find;
                    qpid_next     = walk_req.query_pid;
                    slot_ptr_next = newest_slot;
                    snap_next     = '0;
                    rcnt_next     = '0;
                    found_next    = 1'b0;
                    fage_next     = '0;
                    limit_next    = walk_req.find ? filled : copy;
                    if ((walk_req.find ? filled : copy) == '0)
                    begin
                        state_next = W_FINISH;
                    end
                    else
                    begin
                        state_next = W_SLOT_RD;
                    end
                end
            end
            W_SLOT_RD:
            begin
                base_next  = AW'(slot_ptr_reg) * AW'(MAX_ENTRIES);
                state_next = W_SLOT_DAT;
            end
            W_SLOT_DAT:
            begin
                nent_next  = slot_rd_data[CW-1:0];
                stamp_next = slot_rd_data[CW +: STAMP_W];
                ent_next   = '0;
                if (slot_rd_data[CW-1:0] != '0)
                begin
                    state_next = W_ENT_RD;
                end
                else if (find_reg)
                begin
                    // empty snapshot breaks the run
                    state_next = W_FINISH;
                end
                else
                begin
                    state_next = W_EMIT;
                end
            end
            W_ENT_RD:
            begin
                state_next = find_reg ? W_CHECK : W_EMIT;
            end
            W_CHECK:
            begin
                if (hit)
                begin
                    found_next = 1'b1;
                    fage_next  = (int'(snap_reg) > AGE_MAX) ? AGE_W'(AGE_MAX)
                                                            : AGE_W'(snap_reg);
                    if (snap_inc == limit_reg)
                    begin
                        state_next = W_FINISH;
                    end
                    else
                    begin
                        snap_next     = snap_inc;
                        slot_ptr_next = slot_prev;
                        state_next    = W_SLOT_RD;
                    end
                end
                else if (ent_inc == nent_reg)
                begin
                    state_next = W_FINISH;
                end
                else
                begin
                    ent_next   = ent_inc;
                    state_next = W_ENT_RD;
                end
            end
            W_EMIT:
            begin
                if (rec_take)
                begin
                    rcnt_next = rcnt_reg + RCNT_W'(1);
                    if (run_last)
                    begin
                        state_next = W_IDLE;
                    end
                    else if (snap_last)
                    begin
                        snap_next     = snap_inc;
                        slot_ptr_next = slot_prev;
                        state_next    = W_SLOT_RD;
                    end
                    else
                    begin
                        ent_next   = ent_inc;
                        state_next = W_ENT_RD;
                    end
                end
            end
            W_FINISH:
            begin
                if (rec_take)
                begin
                    state_next = W_IDLE;
                end
            end
            default:
            begin
                state_next = W_IDLE;
            end
        endcase
    end

    // record presented to the output register
    always_comb
    begin
        rec = '0;
        if (state_reg == W_EMIT)
        begin
            rec.kind         = KIND_RECORD;
            rec.age          = AGE_W'(snap_reg);
            rec.stamp_out    = stamp_reg;
            rec.present_out  = (nent_reg != '0);
            rec.pid_out      = (nent_reg != '0) ? ent_pid : '0;
            rec.load_out     = (nent_reg != '0) ? ent_load : '0;
            rec.snapshot_end = snap_last;
            rec.run_end      = run_last;
            rec.count_out    = CNT_W'(limit_reg);
        end
        else if (state_reg == W_FINISH)
        begin
            rec.run_end = 1'b1;
            if (find_reg)
            begin
                rec.kind       = KIND_SEARCH;
                rec.origin_age = found_reg ? signed'({1'b0, fage_reg}) : NO_ORIGIN;
            end
            else
            begin
                rec.kind = KIND_RECORD;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= W_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        find_reg     <= find_next;
        qpid_reg     <= qpid_next;
        slot_ptr_reg <= slot_ptr_next;
        snap_reg     <= snap_next;
        limit_reg    <= limit_next;
        ent_reg      <= ent_next;
        nent_reg     <= nent_next;
        stamp_reg    <= stamp_next;
        base_reg     <= base_next;
        rcnt_reg     <= rcnt_next;
        found_reg    <= found_next;
        fage_reg     <= fage_next;
    end

endmodule

// ===== design/snapshot_history_ring_search_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// snapshot_history_ring_search_unit
// history ring of load snapshots with newest-first read and spike search
// ----------------------------------------------------------------------------
// usage
//   req channel: push entries (one request per entry, entry_last commits the
//   snapshot), read of the newest snapshots, or spike origin search
//   rsp channel: one ack per commit, one record per entry on a read (one for an
//   empty snapshot, at most 64), one answer per search; run_end marks the last response of a request
//   cfg channel: spike_threshold, always ready, write only while idle
// throughput and latency
//   pushes stream at one request per cycle while the response register is free;
//   a commit ack shows up the cycle after the final entry is taken
//   a read does a slot read and takes the slot data per snapshot, then an entry
//   memory read precedes every record of a non-empty snapshot
//   a search does the same slot steps, then an entry read and a check per scanned entry
//   req_ready is low while a read or search walks the ring
// reset
//   pointers, counts and the threshold clear; the ring is empty; the memories
//   are not cleared, only written locations are ever read
// stall
//   the response register holds while rsp_ready is low and req_ready drops
//   until it empties or is taken in the same cycle
// ----------------------------------------------------------------------------
module snapshot_history_ring_search_unit
    import shr_pkg::*;
#(
    parameter int RING_SLOTS  = RING_SLOTS_DEF,
    parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_ready,
    input  req_item_t          req_data,
    output logic               rsp_valid,
    input  logic               rsp_ready,
    output rsp_item_t          rsp_data,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [LOAD_W-1:0]  cfg_data
);

    localparam int SW     = $clog2(RING_SLOTS);
    localparam int FW     = $clog2(RING_SLOTS + 1);
    localparam int CW     = $clog2(MAX_ENTRIES + 1);
    localparam int AW     = $clog2(RING_SLOTS * MAX_ENTRIES);
    localparam int CMPW   = (FW > WANT_W) ? FW : WANT_W;
    localparam int SLOT_W = STAMP_W + CW;
    localparam int ENT_W  = PID_W + LOAD_W;

    // ring pointers and open snapshot state
    logic [SW-1:0]      next_slot_reg;
    logic [FW-1:0]      filled_reg;
    logic [CW-1:0]      fill_pos_reg;
    logic               overflow_reg;
    logic [LOAD_W-1:0]  threshold_reg;

    logic               out_valid_reg;
    rsp_item_t          out_reg;

    logic               req_fire;
    logic               out_free;
    logic               push_fire;
    logic               commit;
    logic               store_entry;
    logic               overflow_now;
    logic [CW-1:0]      fill_after;
    logic [FW-1:0]      filled_after;
    logic [STAMP_W-1:0] commit_stamp;
    logic [SW-1:0]      newest_slot;
    logic [FW-1:0]      copy;
    rsp_item_t          ack_rec;

    logic               ent_wr_en;
    logic [AW-1:0]      ent_wr_addr;
    logic               ent_rd_en;
    logic [AW-1:0]      ent_rd_addr;
    logic [ENT_W-1:0]   ent_rd_data;
    logic               slot_wr_en;
    logic               slot_rd_en;
    logic [SW-1:0]      slot_rd_addr;
    logic [SLOT_W-1:0]  slot_rd_data;

    walk_req_t          walk_req;
    walk_stat_t         walk_stat;
    rsp_item_t          walk_rec;
    logic               rec_take;

    // response register is free when empty or drained this cycle
    assign out_free  = !out_valid_reg || rsp_ready;
    assign req_ready = walk_stat.idle && out_free;
    assign req_fire  = req_valid && req_ready;
    assign cfg_ready = 1'b1;
    assign rsp_valid = out_valid_reg;
    assign rsp_data  = out_reg;

    // push path
    assign push_fire    = req_fire && (req_data.cmd == CMD_PUSH);
    assign commit       = push_fire && req_data.entry_last;
    assign store_entry  = push_fire && req_data.entry_present
                        && (fill_pos_reg < CW'(MAX_ENTRIES));
    assign overflow_now = overflow_reg
                        || (push_fire && req_data.entry_present && !store_entry);
    assign fill_after   = fill_pos_reg + CW'(store_entry);
    assign filled_after = (filled_reg >= FW'(RING_SLOTS)) ? filled_reg
                                                          : filled_reg + FW'(1);
    assign commit_stamp = (req_data.stamp_in != '0) ? req_data.stamp_in
                                                    : req_data.now_time;

    assign ent_wr_en   = store_entry;
    assign ent_wr_addr = AW'(next_slot_reg) * AW'(MAX_ENTRIES) + AW'(fill_pos_reg);
    assign slot_wr_en  = commit;

    // walk setup
    assign newest_slot = (next_slot_reg == '0) ? SW'(RING_SLOTS - 1)
                                               : next_slot_reg - SW'(1);
    assign copy = (CMPW'(req_data.want_count) < CMPW'(filled_reg))
                ? FW'(req_data.want_count) : filled_reg;

    assign walk_req.start     = req_fire
                              && ((req_data.cmd == CMD_READ) || (req_data.cmd == CMD_FIND));
    assign walk_req.find      = (req_data.cmd == CMD_FIND);
    assign walk_req.query_pid = req_data.query_pid;

    assign rec_take = walk_stat.rec_valid && out_free;

    // commit ack
    always_comb
    begin
        ack_rec              = '0;
        ack_rec.kind         = KIND_ACK;
        ack_rec.stamp_out    = commit_stamp;
        ack_rec.snapshot_end = 1'b1;
        ack_rec.run_end      = 1'b1;
        ack_rec.count_out    = CNT_W'(filled_after);
        ack_rec.truncated    = overflow_now;
    end

    shr_ram #(
        .DATA_W (ENT_W),
        .DEPTH  (RING_SLOTS * MAX_ENTRIES)
    ) u_ent_ram (
        .clk     (clk),
        .wr_en   (ent_wr_en),
        .wr_addr (ent_wr_addr),
        .wr_data ({req_data.entry_pid, req_data.entry_load}),
        .rd_en   (ent_rd_en),
        .rd_addr (ent_rd_addr),
        .rd_data (ent_rd_data)
    );

    // per slot stamp and entry count
    shr_ram #(
        .DATA_W (SLOT_W),
        .DEPTH  (RING_SLOTS)
    ) u_slot_ram (
        .clk     (clk),
        .wr_en   (slot_wr_en),
        .wr_addr (next_slot_reg),
        .wr_data ({commit_stamp, fill_after}),
        .rd_en   (slot_rd_en),
        .rd_addr (slot_rd_addr),
        .rd_data (slot_rd_data)
    );

    shr_walk #(
        .RING_SLOTS  (RING_SLOTS),
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_walk (
        .clk          (clk),
        .rst_n        (rst_n),
        .walk_req     (walk_req),
        .newest_slot  (newest_slot),
        .filled       (filled_reg),
        .copy         (copy),
        .threshold    (threshold_reg),
        .slot_rd_en   (slot_rd_en),
        .slot_rd_addr (slot_rd_addr),
        .slot_rd_data (slot_rd_data),
        .ent_rd_en    (ent_rd_en),
        .ent_rd_addr  (ent_rd_addr),
        .ent_rd_data  (ent_rd_data),
        .stat         (walk_stat),
        .rec          (walk_rec),
        .rec_take     (rec_take)
    );

    // ring control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            next_slot_reg <= '0;
            filled_reg    <= '0;
            fill_pos_reg  <= '0;
            overflow_reg  <= 1'b0;
            threshold_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                threshold_reg <= cfg_data;
            end
            if (commit)
            begin
                next_slot_reg <= (next_slot_reg == SW'(RING_SLOTS - 1))
                               ? '0 : next_slot_reg + SW'(1);
                filled_reg    <= filled_after;
                fill_pos_reg  <= '0;
                overflow_reg  <= 1'b0;
            end
            else if (push_fire)
            begin
                fill_pos_reg <= fill_after;
                overflow_reg <= overflow_now;
            end
            if (commit || rec_take)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // response payload, commit ack or walker record
    always_ff @(posedge clk)
    begin
        if (commit)
        begin
            out_reg <= ack_rec;
        end
        else if (rec_take)
        begin
            out_reg <= walk_rec;
        end
    end

endmodule
